/* rtl/core/qmm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmm_pkg
// Shared widths, register map, reset values and stage enables of the
// quadrotor motor mixer.
// ----------------------------------------------------------------------------
package qmm_pkg;

  localparam int unsigned InW     = 24;  // Q4.20 input fields
  localparam int unsigned GainW   = 32;
  localparam int unsigned ProdW   = 56;  // 24 x 32 signed/unsigned product
  localparam int unsigned PairW   = ProdW + 1;
  localparam int unsigned SumW    = ProdW + 2;
  localparam int unsigned FracSh  = 28;
  localparam int unsigned W2W     = 32;
  localparam int unsigned SpeedW  = 16;
  localparam int unsigned DutyW   = 16;
  localparam int unsigned RootSteps = W2W / 2;
  localparam int unsigned NumMotors = 4;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [GainW-1:0] QuadCoeffRst = 32'd32651097;
  localparam logic [GainW-1:0] LinCoeffRst  = 32'd1263;

  typedef enum logic [2:0] {
    REG_THRUST_GAIN     = 3'd0,
    REG_ROLL_PITCH_GAIN = 3'd1,
    REG_YAW_GAIN        = 3'd2,
    REG_QUAD_COEFF      = 3'd3,
    REG_LIN_COEFF       = 3'd4,
    REG_ARMED           = 3'd5
  } reg_idx_e;

  // per-stage load enables, front to back
  typedef struct packed {
    logic                 prod;
    logic                 pair;
    logic                 sq;
    logic [RootSteps-1:0] root;
    logic                 mul;
    logic                 duty;
  } stage_en_t;

endpackage

/* rtl/core/quadrotor_motor_mixer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrotor_motor_mixer_top
// X-frame motor mixer: four lanes turn thrust and torques into rotor speeds
// and PWM duties; an output register merges the lanes into one result item.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  input    | in_valid_i / in_stall_o   | thrust, roll/pitch/yaw torque
//  output   | out_valid_o / out_stall_i | duty_one..four, speed_one..four
//  config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
//  One item per cycle while the output is not stalled; an item passes
//  22 register stages, 16 of them the root steps.
//  Every stage carries a valid bit; an empty stage takes data even while
//  later stages are stalled, so bubbles collapse.
//  Reset clears the valid bits and sets the registers to their defaults.
// ----------------------------------------------------------------------------
module quadrotor_motor_mixer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qmm_pkg::AddrW-1:0]         paddr,
  input  logic [qmm_pkg::DataW-1:0]         pwdata,
  output logic [qmm_pkg::DataW-1:0]         prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [qmm_pkg::InW-1:0]    thrust_i,
  input  logic signed [qmm_pkg::InW-1:0]    roll_torque_i,
  input  logic signed [qmm_pkg::InW-1:0]    pitch_torque_i,
  input  logic signed [qmm_pkg::InW-1:0]    yaw_torque_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [qmm_pkg::DutyW-1:0]         duty_one_o,
  output logic [qmm_pkg::DutyW-1:0]         duty_two_o,
  output logic [qmm_pkg::DutyW-1:0]         duty_three_o,
  output logic [qmm_pkg::DutyW-1:0]         duty_four_o,
  output logic [qmm_pkg::SpeedW-1:0]        speed_one_o,
  output logic [qmm_pkg::SpeedW-1:0]        speed_two_o,
  output logic [qmm_pkg::SpeedW-1:0]        speed_three_o,
  output logic [qmm_pkg::SpeedW-1:0]        speed_four_o
);

  localparam int unsigned NSt = qmm_pkg::RootSteps + 6;
  localparam int unsigned NM  = qmm_pkg::NumMotors;

  // config registers
  logic [qmm_pkg::GainW-1:0] thrust_gain_q, roll_pitch_gain_q, yaw_gain_q;
  logic [qmm_pkg::GainW-1:0] quad_coeff_q, lin_coeff_q;
  logic                      armed_q;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thrust_gain_q     <= '0;
      roll_pitch_gain_q <= '0;
      yaw_gain_q        <= '0;
      quad_coeff_q      <= qmm_pkg::QuadCoeffRst;
      lin_coeff_q       <= qmm_pkg::LinCoeffRst;
      armed_q           <= 1'b0;
    end else if (wr_en) begin
      case (paddr[4:2])
        qmm_pkg::REG_THRUST_GAIN:     thrust_gain_q     <= pwdata;
        qmm_pkg::REG_ROLL_PITCH_GAIN: roll_pitch_gain_q <= pwdata;
        qmm_pkg::REG_YAW_GAIN:        yaw_gain_q        <= pwdata;
        qmm_pkg::REG_QUAD_COEFF:      quad_coeff_q      <= pwdata;
        qmm_pkg::REG_LIN_COEFF:       lin_coeff_q       <= pwdata;
        qmm_pkg::REG_ARMED:           armed_q           <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      qmm_pkg::REG_THRUST_GAIN:     prdata = thrust_gain_q;
      qmm_pkg::REG_ROLL_PITCH_GAIN: prdata = roll_pitch_gain_q;
      qmm_pkg::REG_YAW_GAIN:        prdata = yaw_gain_q;
      qmm_pkg::REG_QUAD_COEFF:      prdata = quad_coeff_q;
      qmm_pkg::REG_LIN_COEFF:       prdata = lin_coeff_q;
      qmm_pkg::REG_ARMED:           prdata = {{(qmm_pkg::DataW-1){1'b0}}, armed_q};
      default:                      prdata = '0;
    endcase
  end

  // pipeline valid bits; stage NSt is the output register
  logic [NSt:1]   vld_q;
  logic [NSt+1:1] rdy;
  qmm_pkg::stage_en_t en;

  always_comb begin
    rdy[NSt+1] = ~out_stall_i;
    for (int k = NSt; k >= 1; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) begin
        vld_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NSt; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign en.prod = rdy[1];
  assign en.pair = rdy[2];
  assign en.sq   = rdy[3];
  assign en.root = rdy[qmm_pkg::RootSteps+3:4];
  assign en.mul  = rdy[qmm_pkg::RootSteps+4];
  assign en.duty = rdy[qmm_pkg::RootSteps+5];

  assign in_stall_o  = ~rdy[1];
  assign out_valid_o = vld_q[NSt];

  logic signed [qmm_pkg::PairW-1:0] t_m_y, t_p_y, r_p_p, r_m_p, n_r_p_p, n_r_m_p;

  qmm_front u_front (
    .clk_i             (clk_i),
    .en_i              (en),
    .thrust_i          (thrust_i),
    .roll_torque_i     (roll_torque_i),
    .pitch_torque_i    (pitch_torque_i),
    .yaw_torque_i      (yaw_torque_i),
    .thrust_gain_i     (thrust_gain_q),
    .roll_pitch_gain_i (roll_pitch_gain_q),
    .yaw_gain_i        (yaw_gain_q),
    .t_m_y_o           (t_m_y),
    .t_p_y_o           (t_p_y),
    .r_p_p_o           (r_p_p),
    .r_m_p_o           (r_m_p),
    .n_r_p_p_o         (n_r_p_p),
    .n_r_m_p_o         (n_r_m_p)
  );

  // motor 1: T-R-P-Y, 2: T-R+P+Y, 3: T+R+P-Y, 4: T+R-P+Y
  logic signed [qmm_pkg::PairW-1:0] op_a [NM];
  logic signed [qmm_pkg::PairW-1:0] op_b [NM];
  logic [qmm_pkg::DutyW-1:0]        lane_duty  [NM];
  logic [qmm_pkg::SpeedW-1:0]       lane_speed [NM];

  assign op_a[0] = t_m_y;  assign op_b[0] = n_r_p_p;
  assign op_a[1] = t_p_y;  assign op_b[1] = n_r_m_p;
  assign op_a[2] = t_m_y;  assign op_b[2] = r_p_p;
  assign op_a[3] = t_p_y;  assign op_b[3] = r_m_p;

  for (genvar m = 0; m < NM; m++) begin : g_lane
    qmm_lane u_lane (
      .clk_i        (clk_i),
      .en_i         (en),
      .op_a_i       (op_a[m]),
      .op_b_i       (op_b[m]),
      .quad_coeff_i (quad_coeff_q),
      .lin_coeff_i  (lin_coeff_q),
      .armed_i      (armed_q),
      .duty_o       (lane_duty[m]),
      .speed_o      (lane_speed[m])
    );
  end

  // merge lanes into the output register
  logic [qmm_pkg::DutyW-1:0]  duty_q  [NM];
  logic [qmm_pkg::SpeedW-1:0] speed_q [NM];

  always_ff @(posedge clk_i) begin
    if (rdy[NSt]) begin
      for (int m = 0; m < NM; m++) begin
        duty_q[m]  <= lane_duty[m];
        speed_q[m] <= lane_speed[m];
      end
    end
  end

  assign duty_one_o    = duty_q[0];
  assign duty_two_o    = duty_q[1];
  assign duty_three_o  = duty_q[2];
  assign duty_four_o   = duty_q[3];
  assign speed_one_o   = speed_q[0];
  assign speed_two_o   = speed_q[1];
  assign speed_three_o = speed_q[2];
  assign speed_four_o  = speed_q[3];

endmodule

/* rtl/core/qmm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmm_front
// Gain products of thrust and torques, then the pair sums shared by the lanes.
// ----------------------------------------------------------------------------
module qmm_front (
  input  logic                                  clk_i,
  input  qmm_pkg::stage_en_t                    en_i,
  input  logic signed [qmm_pkg::InW-1:0]        thrust_i,
  input  logic signed [qmm_pkg::InW-1:0]        roll_torque_i,
  input  logic signed [qmm_pkg::InW-1:0]        pitch_torque_i,
  input  logic signed [qmm_pkg::InW-1:0]        yaw_torque_i,
  input  logic        [qmm_pkg::GainW-1:0]      thrust_gain_i,
  input  logic        [qmm_pkg::GainW-1:0]      roll_pitch_gain_i,
  input  logic        [qmm_pkg::GainW-1:0]      yaw_gain_i,
  output logic signed [qmm_pkg::PairW-1:0]      t_m_y_o,   // T - Y
  output logic signed [qmm_pkg::PairW-1:0]      t_p_y_o,   // T + Y
  output logic signed [qmm_pkg::PairW-1:0]      r_p_p_o,   // R + P
  output logic signed [qmm_pkg::PairW-1:0]      r_m_p_o,   // R - P
  output logic signed [qmm_pkg::PairW-1:0]      n_r_p_p_o, // -R - P
  output logic signed [qmm_pkg::PairW-1:0]      n_r_m_p_o  // P - R
);

  logic signed [qmm_pkg::ProdW-1:0] t_q, r_q, p_q, y_q;
  logic signed [qmm_pkg::PairW-1:0] t_x, r_x, p_x, y_x;

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      t_q <= qmm_pkg::ProdW'($signed(thrust_i) * $signed({1'b0, thrust_gain_i}));
      r_q <= qmm_pkg::ProdW'($signed(roll_torque_i) * $signed({1'b0, roll_pitch_gain_i}));
      p_q <= qmm_pkg::ProdW'($signed(pitch_torque_i) * $signed({1'b0, roll_pitch_gain_i}));
      y_q <= qmm_pkg::ProdW'($signed(yaw_torque_i) * $signed({1'b0, yaw_gain_i}));
    end
  end

  assign t_x = qmm_pkg::PairW'(t_q);
  assign r_x = qmm_pkg::PairW'(r_q);
  assign p_x = qmm_pkg::PairW'(p_q);
  assign y_x = qmm_pkg::PairW'(y_q);

  always_ff @(posedge clk_i) begin
    if (en_i.pair) begin
      t_m_y_o   <= t_x - y_x;
      t_p_y_o   <= t_x + y_x;
      r_p_p_o   <= r_x + p_x;
      r_m_p_o   <= r_x - p_x;
      n_r_p_p_o <= -r_x - p_x;
      n_r_m_p_o <= p_x - r_x;
    end
  end

endmodule

/* rtl/core/qmm_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmm_lane
// One motor: squared speed with clamp, pipelined integer square root and
// duty computation with saturation, zero while the lane is not armed.
// ----------------------------------------------------------------------------
module qmm_lane (
  input  logic                                clk_i,
  input  qmm_pkg::stage_en_t                  en_i,
  input  logic signed [qmm_pkg::PairW-1:0]    op_a_i,
  input  logic signed [qmm_pkg::PairW-1:0]    op_b_i,
  input  logic        [qmm_pkg::GainW-1:0]    quad_coeff_i,
  input  logic        [qmm_pkg::GainW-1:0]    lin_coeff_i,
  input  logic                                armed_i,
  output logic        [qmm_pkg::DutyW-1:0]    duty_o,
  output logic        [qmm_pkg::SpeedW-1:0]   speed_o
);

  localparam int unsigned N = qmm_pkg::RootSteps;
  localparam int unsigned W = qmm_pkg::W2W;

  logic signed [qmm_pkg::SumW-1:0] sum;

  // index 0 is the squared-speed stage, 1..N the root steps
  logic [W-1:0] rem_q  [N+1];
  logic [W-1:0] root_q [N+1];
  logic [W-1:0] w2_q   [N+1];

  assign sum = qmm_pkg::SumW'(op_a_i) + qmm_pkg::SumW'(op_b_i);

  always_ff @(posedge clk_i) begin
    if (en_i.sq) begin
      // sum < 2^57, so the shifted value always fits 32 bits
      if (sum[qmm_pkg::SumW-1]) begin
        w2_q[0]  <= '0;
        rem_q[0] <= '0;
      end else begin
        w2_q[0]  <= W'(sum[qmm_pkg::SumW-2:qmm_pkg::FracSh]);
        rem_q[0] <= W'(sum[qmm_pkg::SumW-2:qmm_pkg::FracSh]);
      end
      root_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_root
    localparam logic [W-1:0] Bit = W'(1) << (W - 2 - 2 * k);
    logic [W:0]   trial;
    logic [W-1:0] rem_d, root_d;

    assign trial = {1'b0, root_q[k]} + {1'b0, Bit};

    always_comb begin
      if ({1'b0, rem_q[k]} >= trial) begin
        rem_d  = rem_q[k] - trial[W-1:0];
        root_d = (root_q[k] >> 1) + Bit;
      end else begin
        rem_d  = rem_q[k];
        root_d = root_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i.root[k]) begin
        rem_q[k+1]  <= rem_d;
        root_q[k+1] <= root_d;
        w2_q[k+1]   <= w2_q[k];
      end
    end
  end

  logic [2*W-1:0]                         quad_q;
  logic [qmm_pkg::SpeedW+W-1:0]           lin_q;
  logic [qmm_pkg::SpeedW-1:0]             spd_mul_q;
  logic [2*W:0]                           duty_sum;
  logic [qmm_pkg::DutyW-1:0]              duty_d;

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      quad_q    <= w2_q[N] * quad_coeff_i;
      lin_q     <= root_q[N][qmm_pkg::SpeedW-1:0] * lin_coeff_i;
      spd_mul_q <= root_q[N][qmm_pkg::SpeedW-1:0];
    end
  end

  assign duty_sum = {1'b0, quad_q} + (2*W+1)'(lin_q);

  always_comb begin
    if (!armed_i) begin
      duty_d = '0;
    end else if (duty_sum[2*W:W+qmm_pkg::DutyW] != '0) begin
      duty_d = '1;
    end else begin
      duty_d = duty_sum[W+qmm_pkg::DutyW-1:W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.duty) begin
      duty_o  <= duty_d;
      speed_o <= spd_mul_q;
    end
  end

endmodule

/* rtl/core/qmm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmm_checker
// Port-level checks of the motor mixer output channel.
// ----------------------------------------------------------------------------
module qmm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [qmm_pkg::DutyW-1:0]  duty_one_o,
  input logic [qmm_pkg::DutyW-1:0]  duty_two_o,
  input logic [qmm_pkg::DutyW-1:0]  duty_three_o,
  input logic [qmm_pkg::DutyW-1:0]  duty_four_o,
  input logic [qmm_pkg::SpeedW-1:0] speed_one_o,
  input logic [qmm_pkg::SpeedW-1:0] speed_two_o,
  input logic [qmm_pkg::SpeedW-1:0] speed_three_o,
  input logic [qmm_pkg::SpeedW-1:0] speed_four_o
);

  a_rst_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(duty_one_o) && $stable(speed_four_o))
    else $error("stalled output item changed");

  // a nonzero duty needs a nonzero squared speed, hence a nonzero speed
  a_duty_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (duty_one_o == '0 || speed_one_o != '0)
                 && (duty_two_o == '0 || speed_two_o != '0)
                 && (duty_three_o == '0 || speed_three_o != '0)
                 && (duty_four_o == '0 || speed_four_o != '0))
    else $error("duty without rotor speed");

endmodule

bind quadrotor_motor_mixer_top qmm_checker u_qmm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .duty_one_o    (duty_one_o),
  .duty_two_o    (duty_two_o),
  .duty_three_o  (duty_three_o),
  .duty_four_o   (duty_four_o),
  .speed_one_o   (speed_one_o),
  .speed_two_o   (speed_two_o),
  .speed_three_o (speed_three_o),
  .speed_four_o  (speed_four_o)
);
